// File: rtl/ffca_pkg.sv
// Package for the first-fit coalescing allocator.
// Shared defaults, request mode codes and result status codes.
// No dependencies.
package ffca_pkg;

   localparam int MAX_FREE_BLOCKS_DEF = 32;
   localparam int ADDR_BITS_DEF       = 16;
   localparam int HEAP_W              = 16;
   localparam int MODE_W              = 2;
   localparam int COUNT_W             = 6;

   typedef logic [MODE_W-1:0] mode_type;

   localparam mode_type MODE_ALLOC  = 2'd0;
   localparam mode_type MODE_FREE   = 2'd1;
   localparam mode_type MODE_REINIT = 2'd2;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NO_FIT = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

endpackage

// File: rtl/ffca_if.sv
// Channel interfaces of the allocator: request, response and register write.
// Depends on ffca_pkg.
interface ffca_req_if #(parameter int ADDR_BITS = ffca_pkg::ADDR_BITS_DEF);
   import ffca_pkg::*;
   logic                 valid;
   logic                 ready;
   mode_type             mode;
   logic [ADDR_BITS-1:0] region_start;
   logic [ADDR_BITS-1:0] byte_count;
   modport source (output valid, mode, region_start, byte_count, input ready);
   modport sink   (input valid, mode, region_start, byte_count, output ready);
endinterface

interface ffca_rsp_if #(parameter int ADDR_BITS = ffca_pkg::ADDR_BITS_DEF);
   import ffca_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ADDR_BITS-1:0] granted_address;
   status_type           status;
   logic [COUNT_W-1:0]   free_blocks;
   modport source (output valid, granted_address, status, free_blocks, input ready);
   modport sink   (input valid, granted_address, status, free_blocks, output ready);
endinterface

interface ffca_csr_if;
   import ffca_pkg::*;
   logic              valid;
   logic              ready;
   logic [HEAP_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: rtl/first_fit_coalescing_allocator.sv
// First-fit free-list allocator with coalescing: top level.
// Depends on ffca_pkg, ffca_if (channel interfaces) and ffca_ram.
//
// The free table (start, size per entry, address order) lives in one RAM with a registered
// read port, and a small sequencer walks it one entry at a time (read, then evaluate or
// move). Allocate: scan entries up to the first fit, then shift later entries down when
// the hit entry empties. Free: scan entries up to the insert point, a merge step, then
// shift entries up (unmerged insert) or down (double merge). Reinit and the reserved mode
// go straight to the response. The scan and shift speed is set by the single RAM read
// port. The block takes no new item while one is in work; the result register lets the
// next item in while a result waits. Table entries need no clearing after reset, since
// only entries below the entry count are ever read.
module first_fit_coalescing_allocator #(
   parameter int MAX_FREE_BLOCKS = ffca_pkg::MAX_FREE_BLOCKS_DEF,
   parameter int ADDR_BITS       = ffca_pkg::ADDR_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ffca_req_if.sink   req_ch,
   ffca_rsp_if.source rsp_ch,
   ffca_csr_if.sink   csr_ch
);
   import ffca_pkg::*;

   localparam int AW    = ADDR_BITS;
   localparam int EW    = 2 * ADDR_BITS;
   localparam int IDX_W = $clog2(MAX_FREE_BLOCKS);
   localparam int CNT_W = $clog2(MAX_FREE_BLOCKS + 1);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_SCAN_RD = 9'b000000010,
      S_SCAN_EV = 9'b000000100,
      S_DECIDE  = 9'b000001000,
      S_DOWN_RD = 9'b000010000,
      S_DOWN_WR = 9'b000100000,
      S_UP_RD   = 9'b001000000,
      S_UP_WR   = 9'b010000000,
      S_RESP    = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   mode_type           op_ff, op_in;
   logic [AW-1:0]      start_ff, start_in;
   logic [AW-1:0]      size_ff, size_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [EW-1:0]      prev_ff, prev_in;
   logic [EW-1:0]      next_ff, next_in;
   logic               has_prev_ff, has_prev_in;
   logic               has_next_ff, has_next_in;
   logic [AW-1:0]      granted_ff, granted_in;
   status_type         status_ff, status_in;
   logic [HEAP_W-1:0]  heap_ff, heap_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]      rsp_granted_ff, rsp_granted_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0] rsp_free_ff, rsp_free_in;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [EW-1:0]    ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [EW-1:0]    ram_rd_data;

   logic             req_acc;
   logic [AW-1:0]    rd_start, rd_size;
   logic [AW-1:0]    prev_start, prev_size, next_start, next_size;
   logic [CNT_W:0]   idx_inc;
   logic [CNT_W-1:0] idx_dec, pos_dec;
   logic [AW:0]      prev_end, req_end;
   logic             adj_prev, adj_next;
   logic [AW+1:0]    msum;
   logic [AW-1:0]    msat;

   ffca_ram #(.WIDTH(EW), .DEPTH(MAX_FREE_BLOCKS)) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_acc       = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE);
   assign csr_ch.ready  = 1'b1;

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.granted_address = rsp_granted_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.free_blocks     = rsp_free_ff;

   assign rd_start   = ram_rd_data[EW-1:AW];
   assign rd_size    = ram_rd_data[AW-1:0];
   assign prev_start = prev_ff[EW-1:AW];
   assign prev_size  = prev_ff[AW-1:0];
   assign next_start = next_ff[EW-1:AW];
   assign next_size  = next_ff[AW-1:0];

   assign idx_inc = {1'b0, idx_ff} + (CNT_W + 1)'(1);
   assign idx_dec = idx_ff - CNT_W'(1);
   assign pos_dec = pos_ff - CNT_W'(1);

   // adjacency without wrap; merging with both sides needs only the two end checks
   assign prev_end = {1'b0, prev_start} + {1'b0, prev_size};
   assign req_end  = {1'b0, start_ff} + {1'b0, size_ff};
   assign adj_prev = has_prev_ff && (prev_end == {1'b0, start_ff});
   assign adj_next = has_next_ff && ({1'b0, next_start} == req_end);
   assign msum     = {2'b00, (adj_prev ? prev_size : next_size)} + {2'b00, size_ff}
                   + ((adj_prev && adj_next) ? {2'b00, next_size} : (AW + 2)'(0));
   assign msat     = (|msum[AW+1:AW]) ? {AW{1'b1}} : msum[AW-1:0];

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      start_in       = start_ff;
      size_in        = size_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      pos_in         = pos_ff;
      prev_in        = prev_ff;
      next_in        = next_ff;
      has_prev_in    = has_prev_ff;
      has_next_in    = has_next_ff;
      granted_in     = granted_ff;
      status_in      = status_ff;
      heap_in        = (csr_ch.valid && csr_ch.ready) ? csr_ch.data : heap_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_free_in    = rsp_free_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = idx_ff[IDX_W-1:0];
      ram_wr_data    = ram_rd_data;
      ram_rd_addr    = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               op_in       = req_ch.mode;
               start_in    = req_ch.region_start;
               size_in     = req_ch.byte_count;
               granted_in  = '0;
               status_in   = ST_OK;
               idx_in      = '0;
               pos_in      = '0;
               has_prev_in = 1'b0;
               has_next_in = 1'b0;
               unique case (req_ch.mode)
                  MODE_ALLOC: begin
                     if (count_ff == '0) begin
                        status_in = ST_NO_FIT;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  MODE_FREE: begin
                     state_in = (count_ff == '0) ? S_DECIDE : S_SCAN_RD;
                  end
                  MODE_REINIT: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = '0;
                     ram_wr_data = {{AW{1'b0}}, AW'(heap_ff)};
                     count_in    = CNT_W'(1);
                     state_in    = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            if (op_ff == MODE_ALLOC) begin
               if (rd_size >= size_ff) begin
                  granted_in = rd_start;
                  if (rd_size == size_ff) begin
                     state_in = S_DOWN_RD;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = {rd_start + size_ff, rd_size - size_ff};
                     state_in    = S_RESP;
                  end
               end else begin
                  idx_in = idx_inc[CNT_W-1:0];
                  if (idx_inc == {1'b0, count_ff}) begin
                     status_in = ST_NO_FIT;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
            end else begin
               if (rd_start < start_ff) begin
                  prev_in     = ram_rd_data;
                  has_prev_in = 1'b1;
                  idx_in      = idx_inc[CNT_W-1:0];
                  if (idx_inc == {1'b0, count_ff}) begin
                     pos_in   = count_ff;
                     state_in = S_DECIDE;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end else begin
                  pos_in      = idx_ff;
                  next_in     = ram_rd_data;
                  has_next_in = 1'b1;
                  state_in    = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            priority if (adj_prev) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pos_dec[IDX_W-1:0];
               ram_wr_data = {prev_start, msat};
               idx_in      = pos_ff;
               state_in    = adj_next ? S_DOWN_RD : S_RESP;
            end else if (adj_next) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pos_ff[IDX_W-1:0];
               ram_wr_data = {start_ff, msat};
               state_in    = S_RESP;
            end else if (count_ff == CNT_W'(MAX_FREE_BLOCKS)) begin
               status_in = ST_FULL;
               state_in  = S_RESP;
            end else begin
               idx_in   = count_ff;
               state_in = S_UP_RD;
            end
         end
         S_DOWN_RD: begin
            if (idx_inc < {1'b0, count_ff}) begin
               ram_rd_addr = idx_inc[IDX_W-1:0];
               state_in    = S_DOWN_WR;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESP;
            end
         end
         S_DOWN_WR: begin
            ram_wr_en = 1'b1;
            idx_in    = idx_inc[CNT_W-1:0];
            state_in  = S_DOWN_RD;
         end
         S_UP_RD: begin
            if (idx_ff > pos_ff) begin
               ram_rd_addr = idx_dec[IDX_W-1:0];
               state_in    = S_UP_WR;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pos_ff[IDX_W-1:0];
               ram_wr_data = {start_ff, size_ff};
               count_in    = count_ff + CNT_W'(1);
               state_in    = S_RESP;
            end
         end
         S_UP_WR: begin
            ram_wr_en = 1'b1;
            idx_in    = idx_dec;
            state_in  = S_UP_RD;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = granted_ff;
               rsp_status_in  = status_ff;
               rsp_free_in    = COUNT_W'(count_ff);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         heap_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         heap_ff      <= heap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      start_ff       <= start_in;
      size_ff        <= size_in;
      idx_ff         <= idx_in;
      pos_ff         <= pos_in;
      prev_ff        <= prev_in;
      next_ff        <= next_in;
      has_prev_ff    <= has_prev_in;
      has_next_ff    <= has_next_in;
      granted_ff     <= granted_in;
      status_ff      <= status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_free_ff    <= rsp_free_in;
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FREE_BLOCKS))
      else $error("free table count beyond capacity");

   a_wr_in_table: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (CNT_W'(ram_wr_addr) <= count_ff))
      else $error("table write past the end of the table");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && status_ff == ST_FULL)
         |-> (count_ff == CNT_W'(MAX_FREE_BLOCKS)))
      else $error("table full reported with room left");

   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && status_ff != ST_OK) |-> (granted_ff == '0))
      else $error("nonzero address on a failed request");

   a_reinit_count: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_ch.mode == MODE_REINIT) |=> (count_ff == CNT_W'(1)))
      else $error("reinit did not leave one entry");

endmodule

// File: rtl/ffca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
